// File: hdl/assert_macros.svh
// Assertion macros for the life generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk, inactive while rst_n is low.
`define TLG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on clk that also holds during reset.
`define TLG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/tlg_pkg.sv
// Package with the shared constants and codes of the toroidal life generator.
package tlg_pkg;

  localparam int MaxWidthDef  = 64;
  localparam int MaxHeightDef = 64;

  localparam int CfgW   = 7;
  localparam int CoordW = 6;
  localparam int ModeW  = 2;
  localparam int StepW  = $clog2(CoordW);

  localparam logic [CfgW-1:0] GridWidthRst  = CfgW'(64);
  localparam logic [CfgW-1:0] GridHeightRst = CfgW'(64);

  localparam logic [ModeW-1:0] MODE_SET  = 2'd0;
  localparam logic [ModeW-1:0] MODE_READ = 2'd1;
  localparam logic [ModeW-1:0] MODE_STEP = 2'd2;
  localparam logic [ModeW-1:0] MODE_NOP  = 2'd3;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // B3/S23 neighbor counts.
  localparam logic [3:0] SurviveLow = 4'd2;
  localparam logic [3:0] BirthCount = 4'd3;

endpackage

// File: hdl/tlg_if.sv
// Valid/ready channel interfaces for the life generator items and results.
interface tlg_in_if;
  import tlg_pkg::*;
  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [CoordW-1:0] col;
  logic [CoordW-1:0] row;
  modport source (output valid, output mode, output col, output row, input ready);
  modport sink   (input valid, input mode, input col, input row, output ready);
endinterface

interface tlg_out_if;
  logic valid;
  logic ready;
  logic cell_alive;
  logic step_done;
  modport source (output valid, output cell_alive, output step_done, input ready);
  modport sink   (input valid, input cell_alive, input step_done, output ready);
endinterface

// File: hdl/toroidal_life_generation.sv
// Top level of the toroidal life generator: sequencer, size registers, result register.
//
// Items arrive on in_chan (mode, col, row) and each gives one result on out_chan
// (cell_alive, step_done); a transfer happens when valid and ready are both high.
// The grid is held one row per word in a synchronous memory of MAX_HEIGHT rows.
// cfg_we writes register cfg_index (0 grid_width, 1 grid_height) with cfg_data.
// Each item first reduces col and row modulo the used size, one bit per cycle.
// A set or read then costs a row read and, for a set, a write back. An advance
// reads the wrap row and row 0, then for each row reads the next row and
// computes and writes the whole row in one go.
// One item is in work at a time; in_chan.ready is high when the sequencer is idle.
// The result sits in an output register, so a stalled receiver holds only the
// next result; the following item may already be taken and worked on.
// After reset the memory is cleared to all dead, one row per cycle, over all
// MAX_HEIGHT rows, during which no item is taken. Sizes reset to 64 by 64.
module toroidal_life_generation #(
  parameter int MAX_WIDTH  = tlg_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = tlg_pkg::MaxHeightDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tlg_in_if.sink                      in_chan,
  tlg_out_if.source                   out_chan,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [tlg_pkg::CfgW-1:0]    cfg_data
);
  import tlg_pkg::*;

  `include "assert_macros.svh"

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int CH = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MOD, ST_CELL_RD, ST_CELL_OP,
    ST_ADV_UP, ST_ADV_CUR, ST_ADV_ROW0, ST_ADV_RD, ST_ADV_WR, ST_RESULT
  } state_t;

  state_t             state_r;
  logic [CfgW-1:0]    grid_w_r, grid_h_r;
  logic [CW-1:0]      eff_w;
  logic [CH-1:0]      eff_h;
  logic [ModeW-1:0]   mode_r;
  logic [CoordW-1:0]  col_sh_r, row_sh_r;
  logic [StepW-1:0]   bit_r;
  logic [CW:0]        rem_x_r, rem_x_nxt, tx;
  logic [CH:0]        rem_y_r, rem_y_nxt, ty;
  logic [YW-1:0]      y_r;
  logic               y_last;
  logic [MAX_WIDTH-1:0] up_r, cur_r, first_r, down_row, next_row;
  logic               res_alive_r, res_step_r;
  logic               out_valid_r, out_alive_r, out_step_r;
  logic               mem_we;
  logic [YW-1:0]      mem_waddr, mem_raddr;
  logic [MAX_WIDTH-1:0] mem_wdata, mem_rdata;
  logic [XW-1:0]      x_idx;

  // Size registers are saturated to the built maximum; zero counts as one.
  assign eff_w = (grid_w_r == '0) ? CW'(1) :
                 (32'(grid_w_r) > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(grid_w_r);
  assign eff_h = (grid_h_r == '0) ? CH'(1) :
                 (32'(grid_h_r) > 32'(MAX_HEIGHT)) ? CH'(MAX_HEIGHT) : CH'(grid_h_r);

  // Restoring remainder step: bring in the next coordinate bit, subtract if it fits.
  assign tx = {rem_x_r[CW-1:0], col_sh_r[CoordW-1]};
  assign ty = {rem_y_r[CH-1:0], row_sh_r[CoordW-1]};
  assign rem_x_nxt = (tx >= {1'b0, eff_w}) ? (tx - {1'b0, eff_w}) : tx;
  assign rem_y_nxt = (ty >= {1'b0, eff_h}) ? (ty - {1'b0, eff_h}) : ty;

  assign x_idx    = rem_x_r[XW-1:0];
  assign y_last   = (y_r == YW'(eff_h - CH'(1)));
  assign down_row = y_last ? first_r : mem_rdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = y_r;
    mem_wdata = next_row;
    mem_raddr = y_r;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      ST_CELL_RD: mem_raddr = rem_y_r[YW-1:0];
      ST_CELL_OP: begin
        mem_we    = (mode_r == MODE_SET);
        mem_waddr = rem_y_r[YW-1:0];
        mem_wdata = mem_rdata | (MAX_WIDTH'(1) << x_idx);
      end
      ST_ADV_UP:  mem_raddr = YW'(eff_h - CH'(1));
      ST_ADV_CUR: mem_raddr = '0;
      ST_ADV_RD:  mem_raddr = YW'(y_r + YW'(1));
      ST_ADV_WR:  mem_we = 1'b1;
      default: ;
    endcase
  end

  tlg_row_mem #(.DEPTH(MAX_HEIGHT), .WIDTH(MAX_WIDTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tlg_life_rule #(.MAX_WIDTH(MAX_WIDTH)) u_rule (
    .up_row   (up_r),
    .cur_row  (cur_r),
    .down_row (down_row),
    .eff_w    (eff_w),
    .next_row (next_row)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= GridWidthRst;
      grid_h_r <= GridHeightRst;
    end else if (cfg_we) begin
      if (cfg_index == REG_GRID_WIDTH) begin
        grid_w_r <= cfg_data;
      end else begin
        grid_h_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      y_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In ST_RESULT the output register is refilled below instead.
      if (out_valid_r && out_chan.ready && (state_r != ST_RESULT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          if (y_r == YW'(MAX_HEIGHT - 1)) begin
            y_r     <= '0;
            state_r <= ST_IDLE;
          end else begin
            y_r <= YW'(y_r + YW'(1));
          end
        end
        ST_IDLE: begin
          if (in_chan.valid) begin
            mode_r   <= in_chan.mode;
            col_sh_r <= in_chan.col;
            row_sh_r <= in_chan.row;
            rem_x_r  <= '0;
            rem_y_r  <= '0;
            bit_r    <= '0;
            state_r  <= ST_MOD;
          end
        end
        ST_MOD: begin
          rem_x_r  <= rem_x_nxt;
          rem_y_r  <= rem_y_nxt;
          col_sh_r <= col_sh_r << 1;
          row_sh_r <= row_sh_r << 1;
          bit_r    <= StepW'(bit_r + StepW'(1));
          if (bit_r == StepW'(CoordW - 1)) begin
            case (mode_r)
              MODE_SET, MODE_READ: state_r <= ST_CELL_RD;
              MODE_STEP: begin
                y_r     <= '0;
                state_r <= ST_ADV_UP;
              end
              default: begin
                res_alive_r <= 1'b0;
                res_step_r  <= 1'b0;
                state_r     <= ST_RESULT;
              end
            endcase
          end
        end
        ST_CELL_RD: state_r <= ST_CELL_OP;
        ST_CELL_OP: begin
          res_alive_r <= (mode_r == MODE_SET) ? 1'b1 : mem_rdata[x_idx];
          res_step_r  <= 1'b0;
          state_r     <= ST_RESULT;
        end
        ST_ADV_UP:  state_r <= ST_ADV_CUR;
        ST_ADV_CUR: begin
          up_r    <= mem_rdata;
          state_r <= ST_ADV_ROW0;
        end
        ST_ADV_ROW0: begin
          cur_r   <= mem_rdata;
          first_r <= mem_rdata;
          state_r <= ST_ADV_RD;
        end
        ST_ADV_RD: state_r <= ST_ADV_WR;
        ST_ADV_WR: begin
          // The old rows stay in registers, so the grid is updated in place.
          up_r  <= cur_r;
          cur_r <= down_row;
          if (y_last) begin
            res_alive_r <= 1'b0;
            res_step_r  <= 1'b1;
            state_r     <= ST_RESULT;
          end else begin
            y_r     <= YW'(y_r + YW'(1));
            state_r <= ST_ADV_RD;
          end
        end
        ST_RESULT: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_alive_r <= res_alive_r;
            out_step_r  <= res_step_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_chan.ready       = (state_r == ST_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.cell_alive = out_alive_r;
  assign out_chan.step_done  = out_step_r;

  `TLG_ASSERT(a_one_kind, out_valid_r |-> !(out_alive_r && out_step_r), "result both alive and done")
  `TLG_ASSERT(a_row_range, (state_r == ST_ADV_WR) |-> (CH'(y_r) < eff_h), "advance row out of range")
  `TLG_ASSERT(a_col_range, (state_r == ST_CELL_OP) |-> (rem_x_r < {1'b0, eff_w}), "column not reduced")
  `TLG_ASSERT(a_no_write_idle, (state_r == ST_IDLE) |-> !mem_we, "grid written while idle")
endmodule

// File: hdl/tlg_row_mem.sv
// Row-wide grid memory: one write port, one read port, registered read data.
module tlg_row_mem #(
  parameter int DEPTH = tlg_pkg::MaxHeightDef,
  parameter int WIDTH = tlg_pkg::MaxWidthDef
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/tlg_life_rule.sv
// Next-state logic of one grid row under B3/S23 with wrap at the used width.
module tlg_life_rule #(
  parameter int MAX_WIDTH = tlg_pkg::MaxWidthDef
) (
  input  logic [MAX_WIDTH-1:0]           up_row,
  input  logic [MAX_WIDTH-1:0]           cur_row,
  input  logic [MAX_WIDTH-1:0]           down_row,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] eff_w,
  output logic [MAX_WIDTH-1:0]           next_row
);
  import tlg_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);

  logic [XW-1:0] wm1;
  logic          up_last;
  logic          cur_last;
  logic          down_last;

  assign wm1       = XW'(eff_w - CW'(1));
  assign up_last   = up_row[wm1];
  assign cur_last  = cur_row[wm1];
  assign down_last = down_row[wm1];

  for (genvar x = 0; x < MAX_WIDTH; x++) begin : g_lane
    logic       ul, cl, dl, ur, cr, dr;
    logic [3:0] sum;
    logic       alive_nxt;

    if (x == 0) begin : g_left_edge
      assign ul = up_last;
      assign cl = cur_last;
      assign dl = down_last;
    end else begin : g_left
      assign ul = up_row[x-1];
      assign cl = cur_row[x-1];
      assign dl = down_row[x-1];
    end

    if (x == MAX_WIDTH - 1) begin : g_right_edge
      assign ur = up_row[0];
      assign cr = cur_row[0];
      assign dr = down_row[0];
    end else begin : g_right
      logic at_end;
      assign at_end = (XW'(x) == wm1);
      assign ur = at_end ? up_row[0]   : up_row[x+1];
      assign cr = at_end ? cur_row[0]  : cur_row[x+1];
      assign dr = at_end ? down_row[0] : down_row[x+1];
    end

    // A cell may be counted more than once on very narrow grids.
    assign sum = 4'(ul) + 4'(up_row[x]) + 4'(ur) + 4'(cr)
               + 4'(dr) + 4'(down_row[x]) + 4'(dl) + 4'(cl);
    assign alive_nxt = cur_row[x] ? ((sum == SurviveLow) || (sum == BirthCount))
                                  : (sum == BirthCount);
    // Columns outside the used area keep their value.
    assign next_row[x] = (CW'(x) < eff_w) ? alive_nxt : cur_row[x];
  end
endmodule
